### hw/rtl/tspm_pkg.sv
// ----------------------------------------------------------------------------
// tspm_pkg
// Shared types, codes and helpers for the two-string plotter motion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tspm_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int CFG_WIDTH = 24;
   localparam int CFG_COUNT = 4;
   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [CFG_WIDTH-1:0] PLOTTER_WIDTH_RESET = 24'd210515;
   localparam logic [CFG_WIDTH-1:0] TICKS_PER_MM_RESET = 24'd953663;
   localparam logic [CFG_WIDTH-1:0] HOME_X_RESET = 24'd105258;
   localparam logic [CFG_WIDTH-1:0] HOME_Y_RESET = 24'd32512;
   localparam logic [31:0] RATE_RESET = 32'd1000;

   typedef enum logic [2:0] {
      REQ_RELATIVE  = 3'd0,
      REQ_ABSOLUTE  = 3'd1,
      REQ_HOME      = 3'd2,
      REQ_FEED_RATE = 3'd3,
      REQ_CARTESIAN = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_PLOTTER_WIDTH = 2'd0,
      CSR_TICKS_PER_MM  = 2'd1,
      CSR_HOME_X        = 2'd2,
      CSR_HOME_Y        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        start;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   function automatic logic [31:0] mag34(input logic signed [33:0] v);
      logic [33:0] n;
      n = v[33] ? 34'(-v) : 34'(v);
      return n[31:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/two_string_plotter_motion_top.sv
// ----------------------------------------------------------------------------
// two_string_plotter_motion_top
// Motion command unit for a plotter hung from two strings.
// ----------------------------------------------------------------------------
// Relative, absolute, feed rate and unknown commands go from idle straight to the
// finish state, which presents the result once the output is free and then returns to idle.
// Home and Cartesian commands first run five serial multiplies and two serial square
// roots, and then the finish state presents their result.
// One command is in flight at a time; a stalled result holds back the next one.
// Reset: lengths clear to zero, feed rate to 1000 Hz, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module two_string_plotter_motion_top #(
   parameter int COORD_BITS = tspm_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [63:0]                         req_tdata,  // arg_a, arg_b
   input  wire logic [2:0]                          req_tuser,  // req_type
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // step_a, step_b, feed_rate, pos_a, pos_b
   output logic [223:0]                             rsp_tdata,
   output logic [0:0]                               rsp_tuser,  // move_valid
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tspm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   localparam logic signed [31:0] COORD_MAX = 32'((64'sd1 <<< (COORD_BITS - 1)) - 1);
   localparam logic signed [31:0] COORD_MIN = -COORD_MAX - 32'sd1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_AY, ST_MUL_AX, ST_MUL_BX, ST_SQRT_A, ST_SQRT_B,
      ST_SCALE_A, ST_SCALE_B, ST_FINISH
   } state_type;

   state_type                       state_ff;
   logic [tspm_pkg::CFG_WIDTH-1:0]  cfg_ff [tspm_pkg::CFG_COUNT];
   logic [2:0]                      type_ff;
   logic signed [31:0]              arg_a_ff;
   logic signed [31:0]              arg_b_ff;
   logic signed [33:0]              x_q8_ff;
   logic [63:0]                     ay2_ff;
   logic [63:0]                     sum_a_ff;
   logic [63:0]                     sum_b_ff;
   logic [31:0]                     amm_ff;
   logic [31:0]                     bmm_ff;
   logic [31:0]                     la_ff;
   logic [31:0]                     lb_ff;
   logic [63:0]                     len_a_ff;
   logic [63:0]                     len_b_ff;
   logic [31:0]                     rate_ff;
   logic                            rsp_valid_ff;
   logic [223:0]                    rsp_data_ff;
   logic                            rsp_move_ff;
   tspm_pkg::mul_req_type           mul_req_ff;
   tspm_pkg::sqrt_req_type          sqrt_req_ff;
   logic                            mul_start_in;
   logic                            sqrt_start_in;
   logic                            mul_done;
   logic [63:0]                     mul_product;
   logic                            sqrt_done;
   logic [31:0]                     sqrt_root;
   logic                            req_accept;
   logic                            out_free;
   logic signed [31:0]              sat_a;
   logic signed [31:0]              sat_b;
   logic signed [33:0]              bx_q8;
   logic [31:0]                     tpm;
   logic [63:0]                     len_a_in;
   logic [63:0]                     len_b_in;
   logic [31:0]                     step_a_in;
   logic [31:0]                     step_b_in;
   logic [31:0]                     rate_in;
   logic                            move_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign tpm        = {8'd0, cfg_ff[tspm_pkg::CSR_TICKS_PER_MM]};

   assign sat_a = ($signed(req_tdata[31:0]) > COORD_MAX) ? COORD_MAX :
                  ($signed(req_tdata[31:0]) < COORD_MIN) ? COORD_MIN :
                  $signed(req_tdata[31:0]);
   assign sat_b = ($signed(req_tdata[63:32]) > COORD_MAX) ? COORD_MAX :
                  ($signed(req_tdata[63:32]) < COORD_MIN) ? COORD_MIN :
                  $signed(req_tdata[63:32]);
   assign bx_q8 = $signed({10'd0, cfg_ff[tspm_pkg::CSR_PLOTTER_WIDTH]}) - x_q8_ff;

   always_comb begin
      mul_start_in  = 1'b0;
      sqrt_start_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            mul_start_in = req_accept && ((req_tuser == tspm_pkg::REQ_HOME) ||
                                          (req_tuser == tspm_pkg::REQ_CARTESIAN));
         end
         ST_MUL_AY, ST_MUL_AX, ST_SCALE_A: begin
            mul_start_in = mul_done;
         end
         ST_MUL_BX: begin
            sqrt_start_in = mul_done;
         end
         ST_SQRT_A: begin
            sqrt_start_in = sqrt_done;
         end
         ST_SQRT_B: begin
            mul_start_in = sqrt_done;
         end
         default: begin
            mul_start_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      move_in   = 1'b0;
      step_a_in = 32'd0;
      step_b_in = 32'd0;
      len_a_in  = len_a_ff;
      len_b_in  = len_b_ff;
      rate_in   = rate_ff;
      case (type_ff)
         tspm_pkg::REQ_RELATIVE: begin
            move_in   = 1'b1;
            step_a_in = arg_a_ff;
            step_b_in = arg_b_ff;
            len_a_in  = len_a_ff + {{32{arg_a_ff[31]}}, arg_a_ff};
            len_b_in  = len_b_ff + {{32{arg_b_ff[31]}}, arg_b_ff};
         end
         tspm_pkg::REQ_ABSOLUTE: begin
            move_in   = 1'b1;
            step_a_in = arg_a_ff - len_a_ff[31:0];
            step_b_in = arg_b_ff - len_b_ff[31:0];
            len_a_in  = {{32{arg_a_ff[31]}}, arg_a_ff};
            len_b_in  = {{32{arg_b_ff[31]}}, arg_b_ff};
         end
         tspm_pkg::REQ_HOME: begin
            len_a_in = {32'd0, la_ff};
            len_b_in = {32'd0, lb_ff};
         end
         tspm_pkg::REQ_FEED_RATE: begin
            rate_in = arg_a_ff;
         end
         tspm_pkg::REQ_CARTESIAN: begin
            move_in   = 1'b1;
            step_a_in = la_ff - len_a_ff[31:0];
            step_b_in = lb_ff - len_b_ff[31:0];
            len_a_in  = {32'd0, la_ff};
            len_b_in  = {32'd0, lb_ff};
         end
         default: begin
            move_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         mul_req_ff.start  <= 1'b0;
         sqrt_req_ff.start <= 1'b0;
         len_a_ff          <= 64'd0;
         len_b_ff          <= 64'd0;
         rate_ff           <= tspm_pkg::RATE_RESET;
      end else begin
         mul_req_ff.start  <= mul_start_in;
         sqrt_req_ff.start <= sqrt_start_in;
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  type_ff  <= req_tuser;
                  arg_a_ff <= $signed(req_tdata[31:0]);
                  arg_b_ff <= $signed(req_tdata[63:32]);
                  if (req_tuser == tspm_pkg::REQ_HOME) begin
                     x_q8_ff         <= $signed({10'd0, cfg_ff[tspm_pkg::CSR_HOME_X]});
                     mul_req_ff.op_a <= {8'd0, cfg_ff[tspm_pkg::CSR_HOME_Y]};
                     mul_req_ff.op_b <= {8'd0, cfg_ff[tspm_pkg::CSR_HOME_Y]};
                     state_ff        <= ST_MUL_AY;
                  end else if (req_tuser == tspm_pkg::REQ_CARTESIAN) begin
                     x_q8_ff         <= {{2{sat_a[31]}}, sat_a} <<< 8;
                     mul_req_ff.op_a <= tspm_pkg::mag34({{2{sat_b[31]}}, sat_b} <<< 8);
                     mul_req_ff.op_b <= tspm_pkg::mag34({{2{sat_b[31]}}, sat_b} <<< 8);
                     state_ff        <= ST_MUL_AY;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_MUL_AY: begin
               if (mul_done) begin
                  ay2_ff          <= mul_product;
                  mul_req_ff.op_a <= tspm_pkg::mag34(x_q8_ff);
                  mul_req_ff.op_b <= tspm_pkg::mag34(x_q8_ff);
                  state_ff        <= ST_MUL_AX;
               end
            end
            ST_MUL_AX: begin
               if (mul_done) begin
                  sum_a_ff        <= mul_product + ay2_ff;
                  mul_req_ff.op_a <= tspm_pkg::mag34(bx_q8);
                  mul_req_ff.op_b <= tspm_pkg::mag34(bx_q8);
                  state_ff        <= ST_MUL_BX;
               end
            end
            ST_MUL_BX: begin
               if (mul_done) begin
                  sum_b_ff             <= mul_product + ay2_ff;
                  sqrt_req_ff.radicand <= sum_a_ff;
                  state_ff             <= ST_SQRT_A;
               end
            end
            ST_SQRT_A: begin
               if (sqrt_done) begin
                  amm_ff               <= sqrt_root;
                  sqrt_req_ff.radicand <= sum_b_ff;
                  state_ff             <= ST_SQRT_B;
               end
            end
            ST_SQRT_B: begin
               if (sqrt_done) begin
                  bmm_ff          <= sqrt_root;
                  mul_req_ff.op_a <= amm_ff;
                  mul_req_ff.op_b <= tpm;
                  state_ff        <= ST_SCALE_A;
               end
            end
            ST_SCALE_A: begin
               if (mul_done) begin
                  la_ff           <= mul_product[55:24];
                  mul_req_ff.op_a <= bmm_ff;
                  mul_req_ff.op_b <= tpm;
                  state_ff        <= ST_SCALE_B;
               end
            end
            ST_SCALE_B: begin
               if (mul_done) begin
                  lb_ff    <= mul_product[55:24];
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  len_a_ff     <= len_a_in;
                  len_b_ff     <= len_b_in;
                  rate_ff      <= rate_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_move_ff  <= move_in;
                  rsp_data_ff  <= {len_b_in, len_a_in, rate_in, step_b_in, step_a_in};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[tspm_pkg::CSR_PLOTTER_WIDTH] <= tspm_pkg::PLOTTER_WIDTH_RESET;
         cfg_ff[tspm_pkg::CSR_TICKS_PER_MM]  <= tspm_pkg::TICKS_PER_MM_RESET;
         cfg_ff[tspm_pkg::CSR_HOME_X]        <= tspm_pkg::HOME_X_RESET;
         cfg_ff[tspm_pkg::CSR_HOME_Y]        <= tspm_pkg::HOME_Y_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         cfg_ff[csr_paddr[3:2]] <= csr_pwdata[tspm_pkg::CFG_WIDTH-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {8'd0, cfg_ff[csr_paddr[3:2]]};

   tspm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   tspm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_move_ff;

endmodule

`default_nettype wire

### hw/rtl/tspm_mul.sv
// ----------------------------------------------------------------------------
// tspm_mul
// Bit-serial 32 x 32 unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tspm_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tspm_pkg::mul_req_type req,
   output logic                      done,
   output logic [63:0]               product
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] mcand_ff;
   logic [63:0] acc_ff;
   logic [32:0] sum_in;

   assign sum_in = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, mcand_ff} : 33'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= busy_ff && !req.start && (cnt_ff == 5'd31);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         mcand_ff <= req.op_a;
         acc_ff   <= {32'd0, req.op_b};
      end else if (busy_ff) begin
         acc_ff <= {sum_in, acc_ff[31:1]};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### hw/rtl/tspm_sqrt.sv
// ----------------------------------------------------------------------------
// tspm_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tspm_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tspm_pkg::sqrt_req_type req,
   output logic                       done,
   output logic [31:0]                root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        fits;

   assign rem_sh = {rem_ff, rad_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= busy_ff && !req.start && (cnt_ff == 5'd31);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rad_ff  <= req.radicand;
         rem_ff  <= 34'd0;
         root_ff <= 32'd0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[61:0], 2'b00};
         rem_ff  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
         root_ff <= {root_ff[30:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

### hw/rtl/tspm_checker.sv
// ----------------------------------------------------------------------------
// tspm_sva_checker
// Port-level checks for the two-string plotter motion unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tspm_sva_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [223:0] rsp_tdata,
   input wire logic [0:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_move_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[63:0] == 64'd0)
      else $error("step fields nonzero without a move");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without work");

endmodule

bind two_string_plotter_motion_top tspm_sva_checker u_tspm_sva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
